// ===== rtl/cftl_pkg.sv =====
`default_nettype none

package cftl_pkg;

   // face codes
   typedef logic [2:0] face_type;
   localparam face_type FACE_FRONT  = 3'd0;
   localparam face_type FACE_RIGHT  = 3'd1;
   localparam face_type FACE_BEHIND = 3'd2;
   localparam face_type FACE_LEFT   = 3'd3;
   localparam face_type FACE_TOP    = 3'd4;
   localparam face_type FACE_BOTTOM = 3'd5;
   localparam int FACE_COUNT = 6;

   // register indexes
   localparam logic CSR_FACE_SIZE    = 1'b0;
   localparam logic CSR_SCREEN_WIDTH = 1'b1;

   // saturation limits for the registers
   localparam int MAX_FACE_SIZE    = 1024;
   localparam int MAX_SCREEN_WIDTH = 2048;

   // q1.16 ratio: quotient bits and the value of one
   localparam int Q_BITS   = 17;
   localparam int CNT_BITS = 5;
   localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

   // result word layout
   localparam int RSP_FIELD_BITS = 74;
   localparam int RSP_BITS       = 80;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // hit counter command
   typedef struct packed {
      logic     update;
      logic     clear;
      face_type face;
   } hit_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/cube_face_texel_lookup_top.sv =====
// channel  | dir | ports            | word
// req      | in  | req_t*           | pixel_x, pixel_y, dir_x, dir_y, dir_z, clear_counts
// rsp      | out | rsp_t*           | face, texel_x, texel_y, screen_index, texel_address,
//          |     |                  | faces_used
// csr      | in  | csr_we/index/data| face_size (0), screen_width (1)
//
// each word makes two divisions on the shared restoring divider (start, 17 steps, done),
// four passes through the one multiplier and the load step; the next word is taken
// only once the sequencer is back in its idle step.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register and the next word is taken meanwhile.
// a stalled result holds the sequencer in its last step until the register frees.
// reset is synchronous: registers back to 256 / 320, all hit counters cleared.
`default_nettype none

module cube_face_texel_lookup_top
   import cftl_pkg::*;
#(
   parameter  int DIR_BITS = 18,
   parameter  int HIT_BITS = 24,
   localparam int REQ_BITS = ((3 * DIR_BITS + 30) / 8) * 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // pixel_x, pixel_y, dir_x, dir_y, dir_z, clear_counts
   input  wire logic [REQ_BITS-1:0] req_tdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // face, texel_x, texel_y, screen_index, texel_address, faces_used
   output logic [RSP_BITS-1:0]      rsp_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [11:0]         csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_U_GO    = 10'b0000000010,
      ST_U_WAIT  = 10'b0000000100,
      ST_V_GO    = 10'b0000001000,
      ST_V_WAIT  = 10'b0000010000,
      ST_MUL_TX  = 10'b0000100000,
      ST_MUL_TY  = 10'b0001000000,
      ST_MUL_SCR = 10'b0010000000,
      ST_MUL_ROW = 10'b0100000000,
      ST_FINISH  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [10:0] face_size_ff;
   logic [11:0] screen_width_ff;
   logic [10:0] size_eff;
   logic [11:0] sw_eff;

   // input fields
   logic [10:0]         in_px, in_py;
   logic [DIR_BITS-1:0] in_dx, in_dy, in_dz;
   logic                in_clear;
   logic [DIR_BITS-1:0] mx, my, mz;
   logic                xn, yn, zn, xp, yp, zp;
   face_type            face_sel;
   logic [DIR_BITS-1:0] u_mag_sel, v_mag_sel, den_mag_sel;
   logic                u_neg_sel, v_neg_sel, den_neg_sel;

   // per word registers
   logic                accept;
   face_type            face_ff;
   logic [10:0]         px_ff, py_ff;
   logic [DIR_BITS-1:0] u_mag_ff, v_mag_ff, den_mag_ff;
   logic                u_neg_ff, v_neg_ff;
   logic [17:0]         off_u_ff, off_u_in, off_v_ff, off_v_in;
   logic [10:0]         tx_ff, tx_in, ty_ff, ty_in;
   logic [21:0]         scr_ff, scr_in;
   logic [31:0]         prod_ff, prod_in;
   logic [17:0]         mul_a;
   logic [13:0]         mul_b;
   logic [13:0]         face_times_size;
   logic [Q_BITS-1:0]   q_sat;
   logic [17:0]         off_new;
   logic [10:0]         t_raw, t_clamp;

   // divider and counters
   logic                div_start;
   logic [DIR_BITS-1:0] div_num;
   div_status_type      div_stat;
   logic [Q_BITS-1:0]   div_quo;
   hit_cmd_type         hit_cmd;
   logic [FACE_COUNT-1:0] used;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   face_type                rsp_face_ff;
   logic [9:0]              rsp_tx_ff, rsp_ty_ff;
   logic [21:0]             rsp_scr_ff;
   logic [22:0]             rsp_addr_ff;
   logic [FACE_COUNT-1:0]   rsp_used_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff    <= 11'd256;
         screen_width_ff <= 12'd320;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FACE_SIZE:    face_size_ff    <= csr_wdata[10:0];
            CSR_SCREEN_WIDTH: screen_width_ff <= csr_wdata;
            default:          face_size_ff    <= face_size_ff;
         endcase
      end
   end

   // effective size and width after saturation
   always_comb begin
      if (face_size_ff == '0) begin
         size_eff = 11'd1;
      end else if (32'(face_size_ff) > MAX_FACE_SIZE) begin
         size_eff = 11'(MAX_FACE_SIZE);
      end else begin
         size_eff = face_size_ff;
      end
      sw_eff = (32'(screen_width_ff) > MAX_SCREEN_WIDTH) ? 12'(MAX_SCREEN_WIDTH)
                                                         : screen_width_ff;
   end

   // unpack request word
   assign in_px    = req_tdata[10:0];
   assign in_py    = req_tdata[21:11];
   assign in_dx    = req_tdata[22 +: DIR_BITS];
   assign in_dy    = req_tdata[22 + DIR_BITS +: DIR_BITS];
   assign in_dz    = req_tdata[22 + 2 * DIR_BITS +: DIR_BITS];
   assign in_clear = req_tdata[22 + 3 * DIR_BITS];

   // signs and magnitudes
   always_comb begin
      xn = in_dx[DIR_BITS-1];
      yn = in_dy[DIR_BITS-1];
      zn = in_dz[DIR_BITS-1];
      xp = !xn && (in_dx != '0);
      yp = !yn && (in_dy != '0);
      zp = !zn && (in_dz != '0);
      mx = xn ? (~in_dx + 1'b1) : in_dx;
      my = yn ? (~in_dy + 1'b1) : in_dy;
      mz = zn ? (~in_dz + 1'b1) : in_dz;
   end

   // dominant axis, later axis wins ties
   always_comb begin
      priority if (mx > my && mx > mz) begin
         face_sel = xp ? FACE_RIGHT : FACE_LEFT;
      end else if (mx <= my && my > mz) begin
         face_sel = yp ? FACE_TOP : FACE_BOTTOM;
      end else begin
         face_sel = zp ? FACE_FRONT : FACE_BEHIND;
      end
   end

   // numerators and denominator per face, sign of a negated term is its positivity
   always_comb begin
      u_mag_sel   = mx;
      u_neg_sel   = xn;
      v_mag_sel   = my;
      v_neg_sel   = yp;
      den_mag_sel = mz;
      den_neg_sel = zn;
      unique case (face_sel)
         FACE_FRONT: begin
            u_mag_sel = mx; u_neg_sel = xn; v_mag_sel = my; v_neg_sel = yp;
            den_mag_sel = mz; den_neg_sel = zn;
         end
         FACE_BEHIND: begin
            u_mag_sel = mx; u_neg_sel = xp; v_mag_sel = my; v_neg_sel = yp;
            den_mag_sel = mz; den_neg_sel = zp;
         end
         FACE_LEFT: begin
            u_mag_sel = mz; u_neg_sel = zn; v_mag_sel = my; v_neg_sel = yp;
            den_mag_sel = mx; den_neg_sel = xp;
         end
         FACE_RIGHT: begin
            u_mag_sel = mz; u_neg_sel = zp; v_mag_sel = my; v_neg_sel = yp;
            den_mag_sel = mx; den_neg_sel = xn;
         end
         FACE_BOTTOM: begin
            u_mag_sel = mx; u_neg_sel = xn; v_mag_sel = mz; v_neg_sel = zp;
            den_mag_sel = my; den_neg_sel = yp;
         end
         FACE_TOP: begin
            u_mag_sel = mx; u_neg_sel = xn; v_mag_sel = mz; v_neg_sel = zn;
            den_mag_sel = my; den_neg_sel = yn;
         end
         default: begin
            u_mag_sel = mx; u_neg_sel = xn; v_mag_sel = my; v_neg_sel = yp;
            den_mag_sel = mz; den_neg_sel = zn;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // capture the word
   always_ff @(posedge clock) begin
      if (accept) begin
         face_ff    <= face_sel;
         px_ff      <= in_px;
         py_ff      <= in_py;
         u_mag_ff   <= u_mag_sel;
         v_mag_ff   <= v_mag_sel;
         den_mag_ff <= den_mag_sel;
         u_neg_ff   <= u_neg_sel ^ den_neg_sel;
         v_neg_ff   <= v_neg_sel ^ den_neg_sel;
      end
   end

   // counters follow the accepted word
   assign hit_cmd.update = accept;
   assign hit_cmd.clear  = in_clear;
   assign hit_cmd.face   = face_sel;

   cftl_hits #(
      .HIT_BITS (HIT_BITS)
   ) u_hits (
      .clock (clock),
      .reset (reset),
      .cmd   (hit_cmd),
      .used  (used)
   );

   // shared divider
   assign div_start = (state_ff == ST_U_GO) || (state_ff == ST_V_GO);
   assign div_num   = (state_ff == ST_V_GO) ? v_mag_ff : u_mag_ff;

   cftl_div #(
      .W (DIR_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (div_num),
      .den_mag (den_mag_ff),
      .status  (div_stat),
      .quo     (div_quo)
   );

   // ratio to offset r + 1.0, zero major axis gives ratio zero
   always_comb begin
      if (den_mag_ff == '0) begin
         q_sat = '0;
      end else if (div_quo > Q_ONE) begin
         q_sat = Q_ONE;
      end else begin
         q_sat = div_quo;
      end
      if ((state_ff == ST_V_WAIT) ? v_neg_ff : u_neg_ff) begin
         off_new = {1'b0, Q_ONE} - {1'b0, q_sat};
      end else begin
         off_new = {1'b0, Q_ONE} + {1'b0, q_sat};
      end
   end

   // texel from the registered product, clamped to the face
   always_comb begin
      t_raw   = prod_ff[27:17];
      t_clamp = (t_raw > (size_eff - 1'b1)) ? (size_eff - 1'b1) : t_raw;
   end

   // face times size by shift and add
   always_comb begin
      face_times_size = ({3'b0, size_eff} & {14{face_ff[0]}})
                      + ({2'b0, size_eff, 1'b0} & {14{face_ff[1]}})
                      + ({1'b0, size_eff, 2'b0} & {14{face_ff[2]}});
   end

   // sequencer and multiplier operand selection
   always_comb begin
      state_in = state_ff;
      off_u_in = off_u_ff;
      off_v_in = off_v_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      scr_in   = scr_ff;
      mul_a    = off_u_ff;
      mul_b    = {3'b0, size_eff};
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_U_GO;
            end
         end
         ST_U_GO: begin
            state_in = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (div_stat.done) begin
               off_u_in = off_new;
               state_in = ST_V_GO;
            end
         end
         ST_V_GO: begin
            state_in = ST_V_WAIT;
         end
         ST_V_WAIT: begin
            if (div_stat.done) begin
               off_v_in = off_new;
               state_in = ST_MUL_TX;
            end
         end
         ST_MUL_TX: begin
            mul_a    = off_u_ff;
            mul_b    = {3'b0, size_eff};
            state_in = ST_MUL_TY;
         end
         ST_MUL_TY: begin
            tx_in    = t_clamp;
            mul_a    = off_v_ff;
            mul_b    = {3'b0, size_eff};
            state_in = ST_MUL_SCR;
         end
         ST_MUL_SCR: begin
            ty_in    = t_clamp;
            mul_a    = {7'b0, py_ff};
            mul_b    = {2'b0, sw_eff};
            state_in = ST_MUL_ROW;
         end
         ST_MUL_ROW: begin
            scr_in   = prod_ff[21:0] + {11'b0, px_ff};
            mul_a    = {4'b0, face_times_size + {3'b0, ty_ff}};
            mul_b    = {3'b0, size_eff};
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // row product held while the finished word waits for the output register
      if (state_ff == ST_FINISH) begin
         prod_in = prod_ff;
      end else begin
         prod_in = 32'(mul_a) * 32'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      off_u_ff <= off_u_in;
      off_v_ff <= off_v_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      scr_ff   <= scr_in;
      prod_ff  <= prod_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_face_ff <= face_ff;
         rsp_tx_ff   <= tx_ff[9:0];
         rsp_ty_ff   <= ty_ff[9:0];
         rsp_scr_ff  <= scr_ff;
         rsp_addr_ff <= prod_ff[22:0] + {12'b0, tx_ff};
         rsp_used_ff <= used;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS - RSP_FIELD_BITS){1'b0}}, rsp_used_ff, rsp_addr_ff,
                        rsp_scr_ff, rsp_ty_ff, rsp_tx_ff, rsp_face_ff};

   // accepted word starts the first division
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_U_GO))
      else $error("accepted word did not start the divider");

   // divider finishes only while the sequencer waits for it
   a_div_done_wait : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> ((state_ff == ST_U_WAIT) || (state_ff == ST_V_WAIT)))
      else $error("divider finished outside a wait step");

   // a pending result always names a real face
   a_face_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_face_ff <= FACE_BOTTOM))
      else $error("result face out of range");

   // divider never restarted while busy
   a_div_no_restart : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/cftl_div.sv =====
`default_nettype none

module cftl_div
   import cftl_pkg::*;
#(
   parameter int W = 18
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [W-1:0]        num_mag,
   input  wire logic [W-1:0]        den_mag,
   output div_status_type           status,
   output logic      [Q_BITS-1:0]   quo
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W:0]          rem_ff, rem_in;
   logic [W-1:0]        den_ff, den_in;
   logic [Q_BITS-1:0]   quo_ff, quo_in;
   logic                ge;
   logic [W:0]          diff;

   // one restoring step per cycle, quotient msb first
   always_comb begin
      ge      = rem_ff >= {1'b0, den_ff};
      diff    = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(Q_BITS);
         rem_in  = {1'b0, num_mag};
         den_in  = den_mag;
         quo_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[Q_BITS-2:0], ge};
         rem_in = {diff[W-1:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/cftl_hits.sv =====
`default_nettype none

module cftl_hits
   import cftl_pkg::*;
#(
   parameter int HIT_BITS = 24
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire hit_cmd_type     cmd,
   output logic [FACE_COUNT-1:0] used
);

   logic [HIT_BITS-1:0] hits_ff [FACE_COUNT];
   logic [HIT_BITS-1:0] hits_in [FACE_COUNT];
   logic [HIT_BITS-1:0] base;

   // optional clear, then a saturating bump of the chosen face
   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         base = (cmd.update && cmd.clear) ? '0 : hits_ff[f];
         hits_in[f] = base;
         if (cmd.update && (cmd.face == 3'(f)) && (base != '1)) begin
            hits_in[f] = base + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < FACE_COUNT; f++) begin
            hits_ff[f] <= '0;
         end
      end else begin
         for (int f = 0; f < FACE_COUNT; f++) begin
            hits_ff[f] <= hits_in[f];
         end
      end
   end

   // faces seen more than once
   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         used[f] = hits_ff[f] > HIT_BITS'(1);
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
   import cftl_pkg::*;

   localparam int DIR_W = 18;
   localparam int HIT_W = 24;
   localparam int REQ_W = 80;
   localparam int CYCLE_LIMIT = 600000;
   localparam longint RATIO_ONE = longint'(Q_ONE);

   // request word, first member in the top bits
   typedef struct packed {
      logic [2:0]              pad;
      logic                    clear_counts;
      logic signed [DIR_W-1:0] dir_z;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_x;
      logic [10:0]             pixel_y;
      logic [10:0]             pixel_x;
   } lookup_req_type;

   // result word
   typedef struct packed {
      logic [5:0]  pad;
      logic [5:0]  faces_used;
      logic [22:0] texel_address;
      logic [21:0] screen_index;
      logic [9:0]  texel_y;
      logic [9:0]  texel_x;
      face_type    face;
   } lookup_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   // pixel_x, pixel_y, dir_x, dir_y, dir_z, clear_counts
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // face, texel_x, texel_y, screen_index, texel_address, faces_used
   logic [RSP_BITS-1:0] rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [11:0]       csr_wdata = '0;

   // predictor state: registers as written and the hit counters
   logic [10:0]       model_face_size = 11'd256;
   logic [11:0]       model_screen_width = 12'd320;
   logic [HIT_W-1:0]  model_face_hits [FACE_COUNT];

   lookup_rsp_type    lookup_expected_q [$];
   int                mismatch_count = 0;
   int                result_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                stall_left = 0;

   cube_face_texel_lookup_top #(
      .DIR_BITS(DIR_W),
      .HIT_BITS(HIT_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure, with the odd long stall
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
         rsp_tready <= 1'b0;
         if ($urandom_range(15) == 0)
            stall_left <= $urandom_range(40, 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // q1.16 quotient, truncated toward zero and saturated at one
   function automatic longint q16_ratio(longint num, longint den);
      longint q;
      bit     neg;
      if (den == 0)
         return 0;
      neg = (num < 0) != (den < 0);
      q = ((num < 0 ? -num : num) << 16) / (den < 0 ? -den : den);
      if (q > RATIO_ONE)
         q = RATIO_ONE;
      return neg ? -q : q;
   endfunction

   // ratio to texel: floor((r + 1) / 2 * size), clamped
   function automatic longint ratio_to_texel(longint r, longint size);
      longint t;
      t = ((r + RATIO_ONE) * size) >> 17;
      if (t > size - 1)
         t = size - 1;
      return t;
   endfunction

   // expected result of one word; advances the hit counters
   function automatic lookup_rsp_type predict_lookup(lookup_req_type w);
      longint         sx, sy, sz, ax, ay, az, u, v, size, sw, tx, ty, idx, addr;
      face_type       f;
      lookup_rsp_type r;
      sx = longint'($signed(w.dir_x));
      sy = longint'($signed(w.dir_y));
      sz = longint'($signed(w.dir_z));
      ax = sx < 0 ? -sx : sx;
      ay = sy < 0 ? -sy : sy;
      az = sz < 0 ? -sz : sz;
      if (w.clear_counts)
         for (int i = 0; i < FACE_COUNT; i++)
            model_face_hits[i] = '0;

      // strict comparisons: ties go to the later axis
      if (ax > ay && ax > az)
         f = (sx > 0) ? FACE_RIGHT : FACE_LEFT;
      else if (ax <= ay && ay > az)
         f = (sy > 0) ? FACE_TOP : FACE_BOTTOM;
      else
         f = (sz > 0) ? FACE_FRONT : FACE_BEHIND;

      case (f)
         FACE_FRONT: begin
            u = q16_ratio(sx, sz);
            v = q16_ratio(-sy, sz);
         end
         FACE_BEHIND: begin
            u = q16_ratio(-sx, -sz);
            v = q16_ratio(-sy, -sz);
         end
         FACE_LEFT: begin
            u = q16_ratio(sz, -sx);
            v = q16_ratio(-sy, -sx);
         end
         FACE_RIGHT: begin
            u = q16_ratio(-sz, sx);
            v = q16_ratio(-sy, sx);
         end
         FACE_BOTTOM: begin
            u = q16_ratio(sx, -sy);
            v = q16_ratio(-sz, -sy);
         end
         default: begin
            u = q16_ratio(sx, sy);
            v = q16_ratio(sz, sy);
         end
      endcase

      // register saturation, size zero acts as one
      size = longint'(model_face_size);
      if (size == 0)
         size = 1;
      if (size > MAX_FACE_SIZE)
         size = MAX_FACE_SIZE;
      sw = longint'(model_screen_width);
      if (sw > MAX_SCREEN_WIDTH)
         sw = MAX_SCREEN_WIDTH;

      tx = ratio_to_texel(u, size);
      ty = ratio_to_texel(v, size);

      // saturating hit counter
      if (model_face_hits[f] != '1)
         model_face_hits[f] = model_face_hits[f] + 1'b1;

      idx = longint'(w.pixel_x) + longint'(w.pixel_y) * sw;
      addr = longint'(f) * size * size + ty * size + tx;
      r = '0;
      r.face = f;
      r.texel_x = tx[9:0];
      r.texel_y = ty[9:0];
      r.screen_index = idx[21:0];
      r.texel_address = addr[22:0];
      for (int i = 0; i < FACE_COUNT; i++)
         r.faces_used[i] = model_face_hits[i] > 1;
      return r;
   endfunction

   task automatic check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result %0d: %s expected %0d, got %0d", result_count, field, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin : rsp_check
      lookup_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (lookup_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d: unexpected word %h", result_count, rsp_tdata);
         end else begin
            want = lookup_expected_q.pop_front();
            check_field("face", want.face, got.face);
            check_field("texel_x", want.texel_x, got.texel_x);
            check_field("texel_y", want.texel_y, got.texel_y);
            check_field("screen_index", want.screen_index, got.screen_index);
            check_field("texel_address", want.texel_address, got.texel_address);
            check_field("faces_used", want.faces_used, got.faces_used);
         end
         result_count++;
      end
   end

   function automatic lookup_req_type make_word(int px, int py, int dx, int dy, int dz,
                                                bit clr);
      lookup_req_type w;
      w = '0;
      w.pixel_x = 11'(px);
      w.pixel_y = 11'(py);
      w.dir_x = DIR_W'(dx);
      w.dir_y = DIR_W'(dy);
      w.dir_z = DIR_W'(dz);
      w.clear_counts = clr;
      return w;
   endfunction

   // sends one word; tvalid is left high so back-to-back words need no gap
   task automatic send_word(lookup_req_type w);
      int gap;
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(15) == 0)
         gap = $urandom_range(60, 1);
      while (gap > 0 || (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         if (gap > 0)
            gap--;
      end
      req_tdata <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      lookup_expected_q.push_back(predict_lookup(w));
      @(negedge clock);
   endtask

   // hold off until every expected word has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (lookup_expected_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [11:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FACE_SIZE)
         model_face_size = value[10:0];
      else
         model_screen_width = value;
      @(negedge clock);
   endtask

   function automatic int rand_between(int lo, int hi);
      return int'($urandom_range(hi - lo)) + lo;
   endfunction

   function automatic int rand_pixel();
      case ($urandom_range(9))
         0: return 0;
         1: return 2047;
         default: return $urandom_range(2047);
      endcase
   endfunction

   function automatic int rand_extreme_dir();
      case ($urandom_range(6))
         0: return -131072;
         1: return -131071;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 131070;
         default: return 131071;
      endcase
   endfunction

   // random word: mostly dominant-axis rays, plus ties, small and extreme values
   function automatic lookup_req_type rand_word();
      int dir [3];
      int major, axis, m, sel;
      sel = $urandom_range(99);
      if (sel < 35) begin
         for (int i = 0; i < 3; i++)
            dir[i] = rand_between(-131072, 131071);
      end else if (sel < 65) begin
         axis = $urandom_range(2);
         m = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(131071, 1);
         major = $urandom_range(1) ? m : -m;
         if ($urandom_range(31) == 0)
            major = -131072;
         for (int i = 0; i < 3; i++)
            dir[i] = (i == axis) ? major : rand_between(-m, m);
      end else if (sel < 80) begin
         for (int i = 0; i < 3; i++)
            dir[i] = rand_between(-3, 3);
      end else if (sel < 90) begin
         m = $urandom_range(131071);
         for (int i = 0; i < 3; i++)
            dir[i] = ($urandom_range(3) == 0) ? rand_between(-m, m)
                                             : ($urandom_range(1) ? m : -m);
      end else begin
         for (int i = 0; i < 3; i++)
            dir[i] = rand_extreme_dir();
      end
      return make_word(rand_pixel(), rand_pixel(), dir[0], dir[1], dir[2],
                       $urandom_range(29) == 0);
   endfunction

   function automatic logic [11:0] rand_face_size();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'd1;
         2: return 12'd1024;
         3: return 12'd2047;
         4: return 12'($urandom_range(4095));
         default: return 12'($urandom_range(1024, 1));
      endcase
   endfunction

   function automatic logic [11:0] rand_screen_width();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'd1;
         2: return 12'd2048;
         3: return 12'd4095;
         default: return 12'($urandom_range(2048, 1));
      endcase
   endfunction

   // every face both ways, zero ray, ties, extremes, counter clear
   task automatic test_face_selection();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(make_word(0, 0, 0, 0, 0, 1'b0));
      send_word(make_word(2047, 2047, 0, 0, 131071, 1'b0));
      send_word(make_word(0, 2047, 0, 0, -131072, 1'b0));
      send_word(make_word(2047, 0, 131071, 0, 0, 1'b0));
      send_word(make_word(1024, 1, -131072, 0, 0, 1'b0));
      send_word(make_word(1, 1024, 0, 131071, 0, 1'b0));
      send_word(make_word(5, 9, 0, -131072, 0, 1'b0));
      send_word(make_word(319, 0, 100, 100, 0, 1'b0));
      send_word(make_word(0, 319, 100, 0, 100, 1'b0));
      send_word(make_word(7, 7, 0, -100, -100, 1'b0));
      send_word(make_word(33, 44, -77, 77, -77, 1'b0));
      send_word(make_word(2047, 2047, 5, -5, 0, 1'b0));
      send_word(make_word(12, 34, 131071, 131071, 131071, 1'b0));
      send_word(make_word(56, 78, -131072, 131071, -131072, 1'b0));
      send_word(make_word(90, 12, 131071, 0, -131072, 1'b0));
      send_word(make_word(0, 0, 1, 0, 0, 1'b0));
      send_word(make_word(0, 0, -1, 0, 0, 1'b0));
      send_word(make_word(100, 200, 3, -2, 1, 1'b1));
      send_word(make_word(1023, 1023, -131071, 65536, -65535, 1'b0));
      send_word(make_word(0, 0, 0, 0, 0, 1'b1));
      send_word(make_word(2047, 2047, 0, 0, -1, 1'b0));
      wait_drain();
   endtask

   // register extremes, saturation and the masked face size bit
   task automatic test_register_extremes();
      logic [11:0] sizes [9];
      logic [11:0] widths [9];
      sizes = '{12'd0, 12'd1, 12'd1024, 12'd2047, 12'd4095, 12'd2, 12'd17, 12'd1023, 12'd2048};
      widths = '{12'd0, 12'd1, 12'd2048, 12'd4095, 12'd4095, 12'd3, 12'd2047, 12'd1, 12'd2049};
      send_idle_pct = 10;
      recv_idle_pct = 10;
      for (int p = 0; p < 9; p++) begin
         write_reg(CSR_FACE_SIZE, sizes[p]);
         write_reg(CSR_SCREEN_WIDTH, widths[p]);
         send_word(make_word(2047, 2047, 0, 0, 0, 1'b0));
         send_word(make_word(2047, 2047, 131071, 131071, 131071, 1'b0));
         send_word(make_word(0, 2047, -131072, 131071, 0, 1'b0));
         for (int i = 0; i < 9; i++)
            send_word(rand_word());
         wait_drain();
      end
      write_reg(CSR_FACE_SIZE, 12'd256);
      write_reg(CSR_SCREEN_WIDTH, 12'd320);
   endtask

   // random words under the given idling, registers changed now and then
   task automatic test_random_traffic(int send_pct, int recv_pct, int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99) begin
            wait_drain();
            write_reg(CSR_FACE_SIZE, rand_face_size());
            write_reg(CSR_SCREEN_WIDTH, rand_screen_width());
         end
         send_word(rand_word());
      end
      wait_drain();
   endtask

   // sender holds off until the block has emptied, then carries on
   task automatic test_drain_pause();
      send_idle_pct = 24;
      recv_idle_pct = 57;
      for (int i = 0; i < 30; i++) begin
         send_word(rand_word());
         if (i % 10 == 9)
            wait_drain();
      end
   endtask

   initial begin
      for (int i = 0; i < FACE_COUNT; i++)
         model_face_hits[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_face_selection();
      test_register_extremes();
      test_random_traffic(24, 57, 420);
      test_random_traffic(57, 24, 420);
      test_random_traffic(0, 0, 340);
      test_drain_pause();
      wait_drain();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && lookup_expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
